// ===== hdl/qmh_pkg.sv =====
// Shared constants, codes and state type for the quaternary min-heap.
package qmh_pkg;

    localparam int DEF_CAPACITY     = 1024;
    localparam int DEF_PAYLOAD_BITS = 20;
    localparam int ARITY            = 4;
    localparam int KEY_W            = 32;
    localparam int OP_W             = 1;
    localparam int STATUS_W         = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_LAST,
        S_DN_RD,
        S_DN_CMP
    } t_state;

endpackage

// ===== hdl/quaternary_min_heap.sv =====
// Quaternary min-heap priority queue: root register plus a row-organized entry memory.
//
// Slave channel: one beat is one operation. s_tuser carries the opcode (push or pop),
// s_tdata the key (unsigned 24.8) and the payload. Master channel: one beat per
// operation, in order. m_tdata carries the popped key and payload (zero for a push)
// and the occupancy after the operation; m_tuser carries the status (ok, pop on
// empty, push on full).
// The result is computed when the operation is accepted and appears in the output
// register on the next cycle; the heap is then restored in the background.
// Entry 0 lives in a register; entries 1..CAPACITY-1 live in a memory of rows of
// four siblings, so one read returns all children of a node. Each level of a sift
// is a row read followed by a compare and write back. A push into an empty or full
// heap, a pop on an empty heap or a pop that empties it needs no sift; a pop first
// loads the last entry in S_DN_LAST before sifting down. For 1024 entries depth is 5.
// A new operation is taken only when the previous sift has finished and the output
// register is free or being read in the same cycle.
// Reset empties the heap at once; the entry memory needs no clearing. A stalled
// receiver holds the result in the output register and blocks further input.
module quaternary_min_heap #(
    parameter  int CAPACITY     = qmh_pkg::DEF_CAPACITY,
    parameter  int PAYLOAD_BITS = qmh_pkg::DEF_PAYLOAD_BITS,
    localparam int CNT_W        = $clog2(CAPACITY + 1),
    localparam int IN_W         = ((qmh_pkg::KEY_W + PAYLOAD_BITS + 7) / 8) * 8,
    localparam int OUT_W        = ((qmh_pkg::KEY_W + PAYLOAD_BITS + CNT_W + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [IN_W-1:0]               i_s_tdata,   // key, payload
    input  logic [qmh_pkg::OP_W-1:0]      i_s_tuser,   // opcode
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [OUT_W-1:0]              o_m_tdata,   // out_key, out_payload, occupancy
    output logic [qmh_pkg::STATUS_W-1:0]  o_m_tuser    // status
);
    import qmh_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int ENT_W = KEY_W + PAYLOAD_BITS;
    localparam int ROWS  = (CAPACITY + 2) / ARITY;
    localparam int ROW_W = (IDX_W > 2) ? IDX_W - 2 : 1;
    localparam int FW    = IDX_W + 2;

    // Registers
    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic                   r_out_valid, n_out_valid;
    logic [KEY_W-1:0]       r_out_key, n_out_key;
    logic [PAYLOAD_BITS-1:0] r_out_pay, n_out_pay;
    t_status                r_out_st, n_out_st;
    logic [CNT_W-1:0]       r_out_occ, n_out_occ;
    logic [ENT_W-1:0]       r_root, n_root;
    logic [ENT_W-1:0]       r_cur, n_cur;
    logic [IDX_W-1:0]       r_pos, n_pos;

    logic [ENT_W-1:0]       r_mem [ROWS][ARITY];
    logic [ENT_W-1:0]       r_rdata [ARITY];

    // Memory and root write control
    logic                   do_wr;
    logic [IDX_W-1:0]       wr_idx;
    logic [ENT_W-1:0]       wr_ent;
    logic [IDX_W-1:0]       wr_m1;
    logic                   mem_we;
    logic [ROW_W-1:0]       mem_wrow;
    logic [1:0]             mem_wlane;
    logic                   mem_re;
    logic [ROW_W-1:0]       mem_rrow;

    // Datapath
    logic                   accept;
    t_opcode                in_op;
    logic [KEY_W-1:0]       in_key;
    logic [PAYLOAD_BITS-1:0] in_pay;
    logic [KEY_W-1:0]       cur_key;
    logic [KEY_W-1:0]       root_key;
    logic [IDX_W-1:0]       up_par;
    logic [IDX_W-1:0]       up_par_m1;
    logic [ENT_W-1:0]       par_ent;
    logic [KEY_W-1:0]       par_key;
    logic [CNT_W-1:0]       last_m1;
    logic [CNT_W-1:0]       cnt_m1;
    logic [FW-1:0]          first;
    logic [FW-1:0]          n_ext;
    logic                   has_child;
    logic [1:0]             best_lane;
    logic [KEY_W-1:0]       best_key;
    logic                   dn_stop;
    logic [IDX_W-1:0]       best_idx;

    assign accept   = i_s_tvalid && o_s_tready;
    assign in_op    = t_opcode'(i_s_tuser);
    assign in_key   = i_s_tdata[KEY_W-1:0];
    assign in_pay   = i_s_tdata[KEY_W +: PAYLOAD_BITS];
    assign cur_key  = r_cur[ENT_W-1 -: KEY_W];
    assign root_key = r_root[ENT_W-1 -: KEY_W];

    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'({r_out_occ, r_out_pay, r_out_key});
    assign o_m_tuser  = r_out_st;

    always_comb begin
        int j;
        up_par    = IDX_W'((r_pos - 1'b1) >> 2);
        up_par_m1 = up_par - 1'b1;
        par_ent   = r_rdata[up_par_m1[1:0]];
        par_key   = par_ent[ENT_W-1 -: KEY_W];
        cnt_m1    = r_count - 1'b1;
        last_m1   = r_count - CNT_W'(2);
        first     = {r_pos, 2'b00} + FW'(1);
        n_ext     = FW'(r_count);
        has_child = first < n_ext;
        // lowest-indexed minimum among the valid children
        best_lane = 2'd0;
        best_key  = r_rdata[0][ENT_W-1 -: KEY_W];
        for (j = 1; j < ARITY; j++) begin
            if ((first + FW'(j) < n_ext) && (r_rdata[j][ENT_W-1 -: KEY_W] < best_key)) begin
                best_lane = 2'(j);
                best_key  = r_rdata[j][ENT_W-1 -: KEY_W];
            end
        end
        dn_stop  = best_key >= cur_key;
        best_idx = IDX_W'(first + FW'(best_lane));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (in_op == OP_PUSH) begin
                        if (r_count != CNT_W'(CAPACITY) && r_count != '0) begin
                            n_state = S_UP_RD;
                        end
                    end else if (r_count > CNT_W'(1)) begin
                        n_state = S_DN_LAST;
                    end
                end
            end
            S_UP_RD: begin
                if (up_par == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (par_key <= cur_key) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_UP_RD;
                end
            end
            S_DN_LAST: n_state = S_DN_RD;
            S_DN_RD: begin
                if (has_child) begin
                    n_state = S_DN_CMP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DN_CMP: begin
                if (dn_stop) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_DN_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and datapath updates
    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out_key   = r_out_key;
        n_out_pay   = r_out_pay;
        n_out_st    = r_out_st;
        n_out_occ   = r_out_occ;
        n_root      = r_root;
        n_cur       = r_cur;
        n_pos       = r_pos;
        do_wr       = 1'b0;
        wr_idx      = r_pos;
        wr_ent      = r_cur;
        mem_re      = 1'b0;
        mem_rrow    = ROW_W'(r_pos);

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out_valid = 1'b1;
                    n_out_key   = '0;
                    n_out_pay   = '0;
                    n_out_st    = ST_OK;
                    if (in_op == OP_PUSH) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_out_st  = ST_FULL;
                            n_out_occ = r_count;
                        end else begin
                            n_count   = r_count + 1'b1;
                            n_out_occ = r_count + 1'b1;
                            n_cur     = {in_key, in_pay};
                            n_pos     = IDX_W'(r_count);
                            if (r_count == '0) begin
                                do_wr  = 1'b1;
                                wr_idx = '0;
                                wr_ent = {in_key, in_pay};
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_out_st  = ST_EMPTY;
                            n_out_occ = '0;
                        end else begin
                            n_out_key = root_key;
                            n_out_pay = r_root[PAYLOAD_BITS-1:0];
                            n_count   = cnt_m1;
                            n_out_occ = cnt_m1;
                            // fetch the last entry, it refills the root
                            mem_re    = 1'b1;
                            mem_rrow  = ROW_W'(last_m1 >> 2);
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (up_par == '0) begin
                    do_wr = 1'b1;
                    if (root_key > cur_key) begin
                        wr_ent = r_root;
                        n_root = r_cur;
                    end
                end else begin
                    mem_re   = 1'b1;
                    mem_rrow = ROW_W'(up_par_m1 >> 2);
                end
            end
            S_UP_CMP: begin
                do_wr = 1'b1;
                if (par_key > cur_key) begin
                    wr_ent = par_ent;
                    n_pos  = up_par;
                end
            end
            S_DN_LAST: begin
                n_cur = r_rdata[cnt_m1[1:0]];
                n_pos = '0;
            end
            S_DN_RD: begin
                if (has_child) begin
                    mem_re   = 1'b1;
                    mem_rrow = ROW_W'(r_pos);
                end else begin
                    do_wr = 1'b1;
                end
            end
            S_DN_CMP: begin
                do_wr = 1'b1;
                if (!dn_stop) begin
                    wr_ent = r_rdata[best_lane];
                    n_pos  = best_idx;
                end
            end
            default: ;
        endcase

        if (do_wr && wr_idx == '0) begin
            n_root = wr_ent;
        end
    end

    assign wr_m1     = wr_idx - 1'b1;
    assign mem_we    = do_wr && (wr_idx != '0);
    assign mem_wrow  = ROW_W'(wr_m1 >> 2);
    assign mem_wlane = wr_m1[1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wrow][mem_wlane] <= wr_ent;
        end
        if (mem_re) begin
            for (int k = 0; k < ARITY; k++) begin
                r_rdata[k] <= r_mem[mem_rrow][k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_key <= n_out_key;
        r_out_pay <= n_out_pay;
        r_out_st  <= n_out_st;
        r_out_occ <= n_out_occ;
        r_root    <= n_root;
        r_cur     <= n_cur;
        r_pos     <= n_pos;
    end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the quaternary min-heap priority queue.
`timescale 1ns / 100ps

module tb;
    import qmh_pkg::*;

    localparam int CAP   = DEF_CAPACITY;
    localparam int PAY_W = DEF_PAYLOAD_BITS;
    localparam int CNT_W = $clog2(CAP + 1);
    localparam int IN_W  = ((KEY_W + PAY_W + 7) / 8) * 8;
    localparam int OUT_W = ((KEY_W + PAY_W + CNT_W + 7) / 8) * 8;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
        t_status          status;
        logic [CNT_W-1:0] occ;
    } t_heap_result;

    typedef struct packed {
        t_opcode          op;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
        logic             fixed;
        t_heap_result     res;
    } t_op_row;

    logic                i_clk;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [IN_W-1:0]     i_s_tdata  = '0;   // key, payload
    logic [OP_W-1:0]     i_s_tuser  = '0;   // opcode
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [OUT_W-1:0]    o_m_tdata;         // out_key, out_payload, occupancy
    logic [STATUS_W-1:0] o_m_tuser;         // status

    quaternary_min_heap u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Heap mirror
    logic [KEY_W-1:0] model_key [CAP];
    logic [PAY_W-1:0] model_pay [CAP];
    int unsigned      model_cnt = 0;

    t_heap_result heap_results [$];
    t_heap_result seen_res;
    t_heap_result want_res;
    t_heap_result blank_res = '0;
    int unsigned  mismatches = 0;

    bit          idle_en    = 1'b1;
    bit          stall_req  = 1'b0;
    bit          stall_done = 1'b0;
    int unsigned stall_cnt  = 0;

    // Directed ops: rows with fixed set carry their result typed in
    t_op_row dir_rows [0:21] = '{
        '{OP_POP,  32'h0000_0000, 20'h00000, 1'b1, '{32'h0, 20'h0, ST_EMPTY, 11'd0}},
        '{OP_PUSH, 32'hFFFF_FFFF, 20'hFFFFF, 1'b1, '{32'h0, 20'h0, ST_OK, 11'd1}},
        '{OP_PUSH, 32'h0000_0000, 20'h00000, 1'b1, '{32'h0, 20'h0, ST_OK, 11'd2}},
        '{OP_PUSH, 32'h0000_0005, 20'h00001, 1'b1, '{32'h0, 20'h0, ST_OK, 11'd3}},
        '{OP_PUSH, 32'h0000_0005, 20'h00002, 1'b1, '{32'h0, 20'h0, ST_OK, 11'd4}},
        '{OP_PUSH, 32'h0000_0005, 20'h00003, 1'b1, '{32'h0, 20'h0, ST_OK, 11'd5}},
        '{OP_PUSH, 32'h0000_0005, 20'h00004, 1'b1, '{32'h0, 20'h0, ST_OK, 11'd6}},
        '{OP_POP,  32'h0000_0000, 20'h00000, 1'b1, '{32'h0, 20'h0, ST_OK, 11'd5}},
        '{OP_POP,  32'h0000_0000, 20'h00000, 1'b0, '0},
        '{OP_POP,  32'hFFFF_FFFF, 20'hFFFFF, 1'b0, '0},
        '{OP_PUSH, 32'hAAAA_AAAA, 20'hAAAAA, 1'b0, '0},
        '{OP_PUSH, 32'h5555_5555, 20'h55555, 1'b0, '0},
        '{OP_PUSH, 32'h0000_0005, 20'h00000, 1'b0, '0},
        '{OP_POP,  32'h0000_0000, 20'h00000, 1'b0, '0},
        '{OP_POP,  32'h0000_0000, 20'h00000, 1'b0, '0},
        '{OP_POP,  32'h0000_0000, 20'h00000, 1'b0, '0},
        '{OP_POP,  32'h0000_0000, 20'h00000, 1'b0, '0},
        '{OP_POP,  32'h0000_0000, 20'h00000, 1'b0, '0},
        '{OP_POP,  32'h0000_0000, 20'h00000, 1'b1, '{32'hFFFF_FFFF, 20'hFFFFF, ST_OK, 11'd0}},
        '{OP_POP,  32'h0000_0000, 20'h00000, 1'b1, '{32'h0, 20'h0, ST_EMPTY, 11'd0}},
        '{OP_PUSH, 32'h0000_0100, 20'h12345, 1'b1, '{32'h0, 20'h0, ST_OK, 11'd1}},
        '{OP_POP,  32'h0000_0000, 20'h00000, 1'b1, '{32'h0000_0100, 20'h12345, ST_OK, 11'd0}}
    };

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("tb NOT OK");
        $finish;
    end

    function automatic void swap_entries(int unsigned a, int unsigned b);
        logic [KEY_W-1:0] tk;
        logic [PAY_W-1:0] tp;
        tk = model_key[a];
        tp = model_pay[a];
        model_key[a] = model_key[b];
        model_pay[a] = model_pay[b];
        model_key[b] = tk;
        model_pay[b] = tp;
    endfunction

    function automatic t_heap_result heap_apply(t_opcode op, logic [KEY_W-1:0] key,
                                                logic [PAY_W-1:0] pay);
        t_heap_result r;
        int unsigned  pos;
        int unsigned  up;
        int unsigned  first;
        int unsigned  stop;
        int unsigned  best;
        r.key    = '0;
        r.pay    = '0;
        r.status = ST_OK;
        if (op == OP_PUSH) begin
            if (model_cnt >= CAP) begin
                r.status = ST_FULL;
            end else begin
                pos = model_cnt;
                model_key[pos] = key;
                model_pay[pos] = pay;
                model_cnt++;
                // equal parent ends the climb
                while (pos > 0) begin
                    up = (pos - 1) >> 2;
                    if (model_key[up] <= model_key[pos])
                        break;
                    swap_entries(up, pos);
                    pos = up;
                end
            end
        end else if (model_cnt == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.key = model_key[0];
            r.pay = model_pay[0];
            model_cnt--;
            model_key[0] = model_key[model_cnt];
            model_pay[0] = model_pay[model_cnt];
            pos = 0;
            forever begin
                first = pos * ARITY + 1;
                if (first >= model_cnt)
                    break;
                stop = (first + ARITY > model_cnt) ? model_cnt : first + ARITY;
                // first of equal minimum children wins
                best = first;
                for (int unsigned c = first + 1; c < stop; c++) begin
                    if (model_key[c] < model_key[best])
                        best = c;
                end
                if (model_key[best] >= model_key[pos])
                    break;
                swap_entries(best, pos);
                pos = best;
            end
        end
        r.occ = CNT_W'(model_cnt);
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return $urandom();
        else if (sel < 85)
            return $urandom_range(0, 15);     // crowd keys to force ties
        else if (sel < 93)
            return 32'hFFFF_FFFF - $urandom_range(0, 3);
        else
            return $urandom_range(0, 3);
    endfunction

    task automatic send_item(t_opcode op, logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay,
                             logic fixed, t_heap_result fixed_res);
        t_heap_result calc;
        while (idle_en && $urandom_range(0, 99) < 31) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(IN_W - KEY_W - PAY_W){1'b0}}, pay, key};
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        calc = heap_apply(op, key, pay);
        heap_results.insert(heap_results.size(), fixed ? fixed_res : calc);
    endtask

    task automatic send_random(int unsigned push_pct);
        if ($urandom_range(0, 99) < push_pct)
            send_item(OP_PUSH, pick_key(), PAY_W'($urandom()), 1'b0, blank_res);
        else
            send_item(OP_POP, $urandom(), PAY_W'($urandom()), 1'b0, blank_res);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (heap_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Sender and run control
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].pay,
                      dir_rows[i].fixed, dir_rows[i].res);
        wait_drained();

        // hold the receiver off while ops keep coming, heap stays shallow
        stall_req = 1'b1;
        repeat (250) send_random(50);
        wait_drained();

        idle_en = 1'b0;
        repeat (200) send_random(70);
        wait_drained();
        idle_en = 1'b1;

        // fill to capacity, then knock on the full heap
        while (model_cnt < CAP)
            send_random(92);
        for (int i = 0; i < 8; i++) begin
            if (i == 4)
                send_item(OP_POP, $urandom(), PAY_W'($urandom()), 1'b0, blank_res);
            else
                send_item(OP_PUSH, pick_key(), PAY_W'($urandom()), 1'b0, blank_res);
        end
        repeat (100) send_random(45);

        wait_drained();
        repeat (24) @(posedge i_clk);
        if (mismatches == 0 && heap_results.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // Receiver backpressure
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_req && !stall_done) begin
                i_m_tready <= 1'b0;
                stall_cnt++;
                if (stall_cnt == 400)
                    stall_done = 1'b1;
            end else if (idle_en) begin
                i_m_tready <= ($urandom_range(0, 99) >= 31);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Result checker: compare each beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen_res.key    = o_m_tdata[KEY_W-1:0];
            seen_res.pay    = o_m_tdata[KEY_W+PAY_W-1:KEY_W];
            seen_res.occ    = o_m_tdata[KEY_W+PAY_W+CNT_W-1:KEY_W+PAY_W];
            seen_res.status = t_status'(o_m_tuser);
            if (heap_results.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected beat: key %h pay %h st %0d occ %0d",
                             seen_res.key, seen_res.pay, seen_res.status, seen_res.occ);
                mismatches++;
            end else begin
                want_res = heap_results.pop_front();
                if (seen_res !== want_res) begin
                    if (mismatches < 10)
                        $display("mismatch: want key %h pay %h st %0d occ %0d,",
                                 want_res.key, want_res.pay, want_res.status, want_res.occ,
                                 " got key %h pay %h st %0d occ %0d",
                                 seen_res.key, seen_res.pay, seen_res.status, seen_res.occ);
                    mismatches++;
                end
            end
        end
    end

endmodule
